// File: src/package_header_index_checker_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the package header index checker
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PACKAGE_HEADER_INDEX_CHECKER_TOP_MACROS_SVH
`define PACKAGE_HEADER_INDEX_CHECKER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define PHIC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("phic assertion failed");
// Next-cycle implication, disabled during reset
`define PHIC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("phic assertion failed");
`else
`define PHIC_ASSERT_NOW(label, clk, rst, ante, cons)
`define PHIC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: src/phic_pkg.sv
// ----------------------------------------------------------------------------
// phic_pkg
// Types, codes and the entry check function of the header index checker.
// ----------------------------------------------------------------------------
package phic_pkg;

   // Number of watched tag slots (one slot cell each)
   localparam int NUM_SLOTS = 7;

   localparam int TAG_W   = 32;
   localparam int STORE_W = 28;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int STATUS_W   = 3;
   localparam int MASK_W     = 7;

   localparam logic [31:0] TYPE_LIMIT = 32'd9;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STORE_LEN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WATCH_BASE = 3'd1;

   // Entry status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_TYPE    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OFFSET_PAST = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ARRAY_PAST  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_STRING_END  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_SKIPPED     = 3'd5;

   // Transaction travelling down the cell chain
   typedef struct packed {
      logic [TAG_W-1:0]     tag;
      logic [STATUS_W-1:0]  status;
      logic                 first;
      logic [NUM_SLOTS-1:0] mask;
   } item_type;

   // Type and bounds check of one index entry against the store size
   function automatic logic [STATUS_W-1:0] check_entry(
      input logic [31:0]        etype,
      input logic [31:0]        offset,
      input logic [31:0]        count,
      input logic [STORE_W-1:0] store
   );
      logic [1:0]         shamt;
      logic               fixed;
      logic               is_string;
      logic [34:0]        need;
      logic [STORE_W-1:0] remain;
      logic [31:0]        store_ext;
      logic [STATUS_W-1:0] result;

      fixed     = 1'b0;
      shamt     = 2'd0;
      is_string = 1'b0;
      case (etype) inside
         32'd1, 32'd2, 32'd7: begin
            fixed = 1'b1;
            shamt = 2'd0;
         end
         32'd3: begin
            fixed = 1'b1;
            shamt = 2'd1;
         end
         32'd4: begin
            fixed = 1'b1;
            shamt = 2'd2;
         end
         32'd5: begin
            fixed = 1'b1;
            shamt = 2'd3;
         end
         32'd6, 32'd8, 32'd9: begin
            is_string = 1'b1;
         end
         default: begin
            fixed = 1'b0;
         end
      endcase

      store_ext = {4'b0, store};
      // only meaningful once the offset is known to lie inside the store
      remain    = store - offset[STORE_W-1:0];
      need      = {3'b0, count} << shamt;

      if (etype > TYPE_LIMIT) begin
         result = ST_BAD_TYPE;
      end else if (offset > store_ext) begin
         result = ST_OFFSET_PAST;
      end else if (fixed && (need > {7'b0, remain})) begin
         result = ST_ARRAY_PAST;
      end else if (is_string && (count != 32'd0) && (offset >= store_ext)) begin
         result = ST_STRING_END;
      end else begin
         result = ST_OK;
      end
      return result;
   endfunction

endpackage

// File: src/phic_check_stage.sv
// ----------------------------------------------------------------------------
// phic_check_stage
// Head of the chain: bounds check, sticky walk error and store size register.
// ----------------------------------------------------------------------------
module phic_check_stage
   import phic_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 up_valid,
   input  logic [31:0]          entry_tag,
   input  logic [31:0]          entry_type,
   input  logic [31:0]          entry_offset,
   input  logic [31:0]          entry_count,
   input  logic                 first_entry,
   input  logic                 store_wen,
   input  logic [STORE_W-1:0]   store_data,
   output logic                 dn_valid,
   output item_type             dn_item
);

   logic [STORE_W-1:0]  store_len_ff, store_len_in;
   logic                err_ff, err_in;
   logic                err_base;
   logic                accept;
   logic [STATUS_W-1:0] status;
   logic                valid_ff, valid_in;
   item_type            item_ff, item_in;

   assign accept = up_valid && load;

   // Status of the incoming entry; a new walk clears the sticky error first
   always_comb begin
      err_base = first_entry ? 1'b0 : err_ff;
      status   = err_base ? ST_SKIPPED
                          : check_entry(entry_type, entry_offset, entry_count,
                                        store_len_ff);
      err_in   = accept ? (err_base || (status != ST_OK)) : err_ff;
   end

   // Store size register
   assign store_len_in = store_wen ? store_data : store_len_ff;

   // Stage register
   always_comb begin
      valid_in       = load ? up_valid : valid_ff;
      item_in        = item_ff;
      if (accept) begin
         item_in.tag    = entry_tag;
         item_in.status = status;
         item_in.first  = first_entry;
         item_in.mask   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         err_ff       <= 1'b0;
         store_len_ff <= '0;
      end else begin
         valid_ff     <= valid_in;
         err_ff       <= err_in;
         store_len_ff <= store_len_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

endmodule

// File: src/phic_slot_cell.sv
// ----------------------------------------------------------------------------
// phic_slot_cell
// One watched tag slot: holds the tag, its found flag and one chain stage.
// ----------------------------------------------------------------------------
module phic_slot_cell
   import phic_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  up_valid,
   input  item_type              up_item,
   input  logic                  tag_wen,
   input  logic [CSR_DATA_W-1:0] tag_data,
   output logic                  dn_valid,
   output item_type              dn_item
);

   logic [TAG_W-1:0] watch_tag_ff, watch_tag_in;
   logic             found_ff, found_in;
   logic             found_base;
   logic             hit;
   logic             take;
   logic             valid_ff, valid_in;
   item_type         item_ff, item_in;

   assign take = load && up_valid;

   // Capture: passing entry, matching tag, slot not yet found in this walk
   always_comb begin
      found_base = up_item.first ? 1'b0 : found_ff;
      hit        = (up_item.status == ST_OK) && !found_base &&
                   (up_item.tag == watch_tag_ff);
      found_in   = take ? (found_base || hit) : found_ff;
   end

   assign watch_tag_in = tag_wen ? tag_data : watch_tag_ff;

   // Stage register; the mask shifts down one place per cell
   always_comb begin
      valid_in = load ? up_valid : valid_ff;
      item_in  = item_ff;
      if (take) begin
         item_in      = up_item;
         item_in.mask = {hit, up_item.mask[NUM_SLOTS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         found_ff     <= 1'b0;
         watch_tag_ff <= '0;
      end else begin
         valid_ff     <= valid_in;
         found_ff     <= found_in;
         watch_tag_ff <= watch_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

endmodule

// File: src/package_header_index_checker_top.sv
// Path: an accepted request is registered in the check stage, then in one stage
// per slot cell, the last cell being the output register that drives rsp_valid.
// Throughput: one transaction per cycle while rsp_ready is high; each stage
// moves when its successor is empty or moving; bubbles close up under a stall.
// Reset (synchronous, active high) empties the chain and clears the found
// flags, the walk error and all configuration registers.
// ----------------------------------------------------------------------------
// package_header_index_checker_top
// Header index entry checker: bounds check followed by a chain of slot cells.
// ----------------------------------------------------------------------------
`include "package_header_index_checker_top_macros.svh"

module package_header_index_checker_top
   import phic_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [31:0]           req_entry_tag,
   input  logic [31:0]           req_entry_type,
   input  logic [31:0]           req_entry_offset,
   input  logic [31:0]           req_entry_count,
   input  logic                  req_first_entry,
   input  logic                  req_last_entry,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_entry_status,
   output logic [MASK_W-1:0]     rsp_capture_mask,
   output logic                  rsp_walk_ok,
   // configuration
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic                 front_valid;
   item_type             front_item;
   logic                 front_move;
   logic [NUM_SLOTS-1:0] cell_valid;
   item_type             cell_item [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] cell_move;
   logic [NUM_SLOTS-1:0] down_move;
   logic [NUM_SLOTS-1:0] tag_wen;
   logic                 store_wen;
   item_type             out_item;
   logic                 last_seen;

   // The last-entry flag is only used by the checks; the verdict is walk_ok itself
   assign last_seen = req_last_entry;

   // Register decode
   assign store_wen = csr_write_en && (csr_index == REG_STORE_LEN);

   // Move chain: a stage loads when it is empty or its successor moves
   assign front_move = !front_valid || cell_move[0];
   assign req_ready  = front_move;

   phic_check_stage u_check (
      .clock        (clock),
      .reset        (reset),
      .load         (front_move),
      .up_valid     (req_valid),
      .entry_tag    (req_entry_tag),
      .entry_type   (req_entry_type),
      .entry_offset (req_entry_offset),
      .entry_count  (req_entry_count),
      .first_entry  (req_first_entry),
      .store_wen    (store_wen),
      .store_data   (csr_write_data[STORE_W-1:0]),
      .dn_valid     (front_valid),
      .dn_item      (front_item)
   );

   // Row of slot cells
   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      assign tag_wen[i] = csr_write_en &&
                          (csr_index == CSR_IDX_W'(REG_WATCH_BASE + CSR_IDX_W'(i)));

      if (i == NUM_SLOTS - 1) begin : g_tail
         assign down_move[i] = rsp_ready;
      end else begin : g_body
         assign down_move[i] = cell_move[i+1];
      end
      assign cell_move[i] = !cell_valid[i] || down_move[i];

      if (i == 0) begin : g_head
         phic_slot_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .load     (cell_move[i]),
            .up_valid (front_valid),
            .up_item  (front_item),
            .tag_wen  (tag_wen[i]),
            .tag_data (csr_write_data),
            .dn_valid (cell_valid[i]),
            .dn_item  (cell_item[i])
         );
      end else begin : g_link
         phic_slot_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .load     (cell_move[i]),
            .up_valid (cell_valid[i-1]),
            .up_item  (cell_item[i-1]),
            .tag_wen  (tag_wen[i]),
            .tag_data (csr_write_data),
            .dn_valid (cell_valid[i]),
            .dn_item  (cell_item[i])
         );
      end
   end

   // Response from the last cell
   assign out_item         = cell_item[NUM_SLOTS-1];
   assign rsp_valid        = cell_valid[NUM_SLOTS-1];
   assign rsp_entry_status = out_item.status;
   assign rsp_capture_mask = MASK_W'(out_item.mask);
   assign rsp_walk_ok      = (out_item.status == ST_OK);

   // Checks
   `PHIC_ASSERT_NOW(a_fail_no_capture, clock, reset,
      rsp_valid && (rsp_entry_status != ST_OK), rsp_capture_mask == '0)
   `PHIC_ASSERT_NOW(a_status_range, clock, reset,
      rsp_valid, (rsp_entry_status <= ST_SKIPPED))
   `PHIC_ASSERT_NOW(a_no_block_when_drained, clock, reset,
      rsp_ready, req_ready)
   `PHIC_ASSERT_NEXT(a_last_skipped_fails, clock, reset,
      req_valid && req_ready && last_seen && !req_first_entry &&
      front_valid && (front_item.status != ST_OK) && cell_move[0],
      front_valid && (front_item.status == ST_SKIPPED))

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the package header index checker. Index entries
// are pushed through the request channel under random flow control. Each
// transaction is predicted by a scoreboard that tracks the walk state and
// the register settings. Results are compared field by field, in order.
// ----------------------------------------------------------------------------
module tb
   import phic_pkg::*;
();

   // Index entry data type codes
   typedef enum logic [31:0] {
      TY_NULL         = 32'd0,
      TY_CHAR         = 32'd1,
      TY_INT8         = 32'd2,
      TY_INT16        = 32'd3,
      TY_INT32        = 32'd4,
      TY_INT64        = 32'd5,
      TY_STRING       = 32'd6,
      TY_BIN          = 32'd7,
      TY_STRING_ARRAY = 32'd8,
      TY_I18N_STRING  = 32'd9
   } data_code_type;

   typedef struct {
      logic [31:0] tag;
      logic [31:0] etype;
      logic [31:0] offset;
      logic [31:0] count;
      logic        first;
      logic        last;
   } index_entry_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [MASK_W-1:0]   mask;
      logic                walk_ok;
   } entry_verdict_type;

   // Walk-state predictor and in-order store of expected verdicts
   class walk_scoreboard_type;
      logic [STORE_W-1:0]   store_len;
      logic [TAG_W-1:0]     watch_tag [NUM_SLOTS];
      logic [NUM_SLOTS-1:0] slot_found;
      bit                   error_seen;
      entry_verdict_type    verdict_q [$];
      int                   failures;
      int                   checked;
      int                   captures;
      int                   walks_started;
      int                   status_seen [8];

      function new();
         store_len  = '0;
         foreach (watch_tag[i]) watch_tag[i] = '0;
         slot_found = '0;
         error_seen = 1'b0;
         failures   = 0;
         checked    = 0;
         captures   = 0;
         walks_started = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == REG_STORE_LEN) begin
            store_len = data[STORE_W-1:0];
         end else if (idx >= REG_WATCH_BASE && idx < REG_WATCH_BASE + NUM_SLOTS) begin
            watch_tag[idx - REG_WATCH_BASE] = data;
         end
      endfunction

      // Bytes per element of a fixed-width array type, 0 otherwise
      function logic [31:0] elem_width(logic [31:0] etype);
         case (etype)
            TY_CHAR, TY_INT8, TY_BIN: return 32'd1;
            TY_INT16:                 return 32'd2;
            TY_INT32:                 return 32'd4;
            TY_INT64:                 return 32'd8;
            default:                  return 32'd0;
         endcase
      endfunction

      function logic [STATUS_W-1:0] bounds_status(index_entry_type e);
         logic [31:0] width;
         logic [31:0] store_ext;
         logic [63:0] span;
         logic [63:0] room;
         width     = elem_width(e.etype);
         store_ext = {4'b0, store_len};
         if (e.etype > TYPE_LIMIT) return ST_BAD_TYPE;
         if (e.offset > store_ext) return ST_OFFSET_PAST;
         span = 64'(e.count) * 64'(width);
         room = 64'(store_ext - e.offset);
         if (width != 0 && span > room) return ST_ARRAY_PAST;
         if ((e.etype == TY_STRING || e.etype == TY_STRING_ARRAY ||
              e.etype == TY_I18N_STRING) && e.count != 0 && e.offset >= store_ext)
            return ST_STRING_END;
         return ST_OK;
      endfunction

      // Accepted request: advance the walk and queue its verdict
      function void note_entry(index_entry_type e);
         entry_verdict_type    v;
         logic [NUM_SLOTS-1:0] grab;
         grab = '0;
         if (e.first) begin
            slot_found = '0;
            error_seen = 1'b0;
            walks_started++;
         end
         if (error_seen) begin
            v.status = ST_SKIPPED;
         end else begin
            v.status = bounds_status(e);
            if (v.status != ST_OK) begin
               error_seen = 1'b1;
            end else begin
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (!slot_found[i] && watch_tag[i] == e.tag) grab[i] = 1'b1;
               slot_found = slot_found | grab;
            end
         end
         v.mask    = MASK_W'(grab);
         v.walk_ok = !error_seen;
         verdict_q.push_back(v);
      endfunction

      // Accepted response: compare with the oldest expected verdict
      function void check_result(logic [STATUS_W-1:0] status, logic [MASK_W-1:0] mask,
                                 logic walk_ok);
         entry_verdict_type v;
         if (verdict_q.size() == 0) begin
            $error("response with nothing outstanding: status %0d mask %b walk_ok %0d",
                   status, mask, walk_ok);
            failures++;
            return;
         end
         v = verdict_q.pop_front();
         checked++;
         if (status !== v.status) begin
            $error("entry_status: expected %0d, got %0d", v.status, status);
            failures++;
         end
         if (mask !== v.mask) begin
            $error("capture_mask: expected %b, got %b", v.mask, mask);
            failures++;
         end
         if (walk_ok !== v.walk_ok) begin
            $error("walk_ok: expected %0d, got %0d", v.walk_ok, walk_ok);
            failures++;
         end
         status_seen[v.status]++;
         captures += $countones(v.mask);
      endfunction

      function int pending();
         return verdict_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [31:0]           req_entry_tag = '0;
   logic [31:0]           req_entry_type = '0;
   logic [31:0]           req_entry_offset = '0;
   logic [31:0]           req_entry_count = '0;
   logic                  req_first_entry = 1'b0;
   logic                  req_last_entry = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_entry_status;
   logic [MASK_W-1:0]     rsp_capture_mask;
   logic                  rsp_walk_ok;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   walk_scoreboard_type sb = new();

   int tx_idle_pct = 38;
   int rx_idle_pct = 68;
   int settings_used = 0;
   bit hold_armed = 1'b1;
   int hold_left = 0;

   package_header_index_checker_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_entry_tag    (req_entry_tag),
      .req_entry_type   (req_entry_type),
      .req_entry_offset (req_entry_offset),
      .req_entry_count  (req_entry_count),
      .req_first_entry  (req_first_entry),
      .req_last_entry   (req_last_entry),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_entry_status (rsp_entry_status),
      .rsp_capture_mask (rsp_capture_mask),
      .rsp_walk_ok      (rsp_walk_ok),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side flow control, with one long hold-off to back the chain up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_armed && sb.checked >= 300) begin
         hold_armed <= 1'b0;
         hold_left  <= 150;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_entry_status, rsp_capture_mask, rsp_walk_ok);
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("package_header_index_checker_top verification failed");
      $finish;
   end

   function automatic index_entry_type compose_entry(logic [31:0] tag, logic [31:0] etype,
                                                     logic [31:0] offset,
                                                     logic [31:0] count,
                                                     logic first, logic last);
      index_entry_type e;
      e.tag    = tag;
      e.etype  = etype;
      e.offset = offset;
      e.count  = count;
      e.first  = first;
      e.last   = last;
      return e;
   endfunction

   function automatic logic [31:0] pick_tag();
      case ($urandom_range(0, 3))
         0, 1:    return sb.watch_tag[$urandom_range(0, NUM_SLOTS - 1)];
         2:       return $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   // Mostly in-bounds entry with random content; a few break the walk
   function automatic index_entry_type make_sound_entry(bit first, bit last);
      index_entry_type e;
      logic [31:0]     store_ext;
      logic [31:0]     width;
      logic [31:0]     maxc;
      int              roll;
      store_ext = {4'b0, sb.store_len};
      e.tag   = pick_tag();
      e.first = first;
      e.last  = last;
      e.etype = $urandom_range(0, 9);
      roll    = $urandom_range(0, 99);
      if (roll < 15) e.offset = store_ext;
      else           e.offset = $urandom_range(0, store_ext);
      width = sb.elem_width(e.etype);
      roll  = $urandom_range(0, 99);
      if (width != 0) begin
         maxc = (store_ext - e.offset) / width;
         if (roll < 20)      e.count = maxc;
         else if (roll < 30) e.count = 0;
         else if (roll < 35) e.count = maxc + 1;
         else                e.count = $urandom_range(0, maxc);
      end else begin
         if (roll < 10) e.count = $urandom();
         else           e.count = $urandom_range(0, 3);
      end
      // occasional bad type or stray offset
      roll = $urandom_range(0, 99);
      if (roll < 4)      e.etype  = $urandom_range(32'hFFFF_FFFF, 10);
      else if (roll < 7) e.offset = $urandom_range(32'hFFFF_FFFF, store_ext + 1);
      return e;
   endfunction

   function automatic index_entry_type make_noise_entry();
      return compose_entry($urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom_range(0, 1), $urandom_range(0, 1));
   endfunction

   // Present one transaction and hold it until accepted
   task automatic send_entry(index_entry_type e);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_entry_tag    <= e.tag;
      req_entry_type   <= e.etype;
      req_entry_offset <= e.offset;
      req_entry_count  <= e.count;
      req_first_entry  <= e.first;
      req_last_entry   <= e.last;
      do @(posedge clock); while (!req_ready);
      sb.note_entry(e);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // New register setting once the chain has drained; random watch tags
   // with repeats and extremes unless given
   task automatic configure(logic [31:0] store, bit fixed_tags,
                            logic [31:0] given [NUM_SLOTS]);
      logic [31:0] tags [NUM_SLOTS];
      wait_for_results();
      repeat (12) @(posedge clock);
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (fixed_tags) begin
            tags[i] = given[i];
         end else begin
            case ($urandom_range(0, 5))
               0:       tags[i] = '0;
               1:       tags[i] = 32'hFFFF_FFFF;
               2:       tags[i] = (i > 0) ? tags[i-1] : $urandom();
               3:       tags[i] = $urandom_range(0, 15);
               default: tags[i] = $urandom();
            endcase
         end
      end
      write_reg(REG_STORE_LEN, store);
      for (int i = 0; i < NUM_SLOTS; i++)
         write_reg(CSR_IDX_W'(REG_WATCH_BASE + i), tags[i]);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   // Random walks with some noise, broken walks and stray last markers
   task automatic run_walks(int n_items, bit pause_midway);
      int sent;
      int len;
      bit drop_first;
      bit drop_last;
      bit paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < n_items) begin
         if (pause_midway && !paused && sent >= n_items / 2) begin
            wait_for_results();
            paused = 1'b1;
         end
         if ($urandom_range(0, 99) < 8) begin
            send_entry(make_noise_entry());
            sent++;
         end else begin
            len        = $urandom_range(1, 8);
            drop_first = ($urandom_range(0, 99) < 8);
            drop_last  = ($urandom_range(0, 99) < 8);
            for (int k = 0; k < len; k++) begin
               send_entry(make_sound_entry(k == 0 && !drop_first,
                                           (k == len - 1 && !drop_last) ||
                                           ($urandom_range(0, 99) < 3)));
               sent++;
            end
         end
      end
   endtask

   initial begin
      logic [31:0] dir_tags [NUM_SLOTS];
      logic [31:0] seg_store;
      dir_tags = '{32'd1000, 32'd1000, 32'hFFFF_FFFF, 32'd0, 32'd256,
                   32'hA5A5_A5A5, 32'h5A5A_5A5A};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed walks: store of 100 bytes, upper write bits dropped
      configure(32'hF000_0064, 1'b1, dir_tags);
      send_entry(compose_entry(32'd1000, TY_NULL, 0, 0, 1, 0));
      send_entry(compose_entry(32'd1000, TY_CHAR, 0, 100, 0, 0));
      send_entry(compose_entry(32'hFFFF_FFFF, TY_I18N_STRING, 99, 1, 0, 0));
      send_entry(compose_entry(32'd0, TY_INT64, 92, 1, 0, 0));
      send_entry(compose_entry(32'd256, TY_INT64, 93, 1, 0, 0));
      send_entry(compose_entry(32'd256, TY_NULL, 0, 0, 0, 0));
      send_entry(compose_entry(32'd256, TY_NULL, 0, 0, 0, 1));
      send_entry(compose_entry(32'd7, 32'd10, 0, 0, 1, 0));
      send_entry(compose_entry(32'd7, 32'hFFFF_FFFF, 0, 0, 1, 0));
      send_entry(compose_entry(32'd7, TY_NULL, 101, 0, 1, 0));
      send_entry(compose_entry(32'd7, TY_NULL, 32'hFFFF_FFFF, 0, 1, 0));
      send_entry(compose_entry(32'd7, TY_STRING, 100, 1, 1, 0));
      send_entry(compose_entry(32'd7, TY_STRING, 100, 0, 1, 0));
      send_entry(compose_entry(32'd7, TY_STRING_ARRAY, 100, 5, 1, 0));
      send_entry(compose_entry(32'd7, TY_INT16, 0, 50, 1, 0));
      send_entry(compose_entry(32'd7, TY_INT32, 0, 32'hFFFF_FFFF, 0, 0));
      // verdict on the last entry, then the same walk carries on
      send_entry(compose_entry(32'h5A5A_5A5A, TY_CHAR, 100, 0, 1, 1));
      send_entry(compose_entry(32'd1000, TY_NULL, 0, 0, 0, 0));
      send_entry(compose_entry(32'd256, TY_NULL, 0, 0, 0, 0));
      send_entry(compose_entry(32'd1000, TY_BIN, 0, 100, 1, 0));
      send_entry(compose_entry(32'd1000, TY_BIN, 0, 101, 1, 0));
      send_entry(compose_entry(32'hA5A5_A5A5, TY_INT32, 96, 1, 1, 1));
      // empty store
      configure(32'd0, 1'b1, dir_tags);
      send_entry(compose_entry(32'd0, TY_NULL, 0, 0, 1, 0));
      send_entry(compose_entry(32'd0, TY_INT8, 0, 1, 1, 0));
      send_entry(compose_entry(32'd0, TY_STRING, 0, 1, 1, 0));
      send_entry(compose_entry(32'd0, TY_I18N_STRING, 0, 0, 1, 1));

      // Random segments: sender-light, receiver-light, then no idling
      for (int seg = 0; seg < 6; seg++) begin
         case (seg)
            0:       seg_store = 32'hFFFF_FFFF;
            1:       seg_store = 32'd0;
            2:       seg_store = $urandom_range(1, 64);
            3:       seg_store = $urandom();
            4:       seg_store = 32'd1;
            default: seg_store = $urandom_range(65, 4096);
         endcase
         configure(seg_store, 1'b0, dir_tags);
         tx_idle_pct = (seg < 2) ? 38 : (seg < 4) ? 68 : 0;
         rx_idle_pct = (seg < 2) ? 68 : (seg < 4) ? 38 : 0;
         run_walks(190, seg == 4);
      end

      wait_for_results();
      repeat (20) @(posedge clock);
      $display("Checked %0d entries in %0d walks over %0d register settings, %0d captures",
               sb.checked, sb.walks_started, settings_used, sb.captures);
      $display("Status mix: ok %0d, bad type %0d, offset %0d, array %0d, string %0d, skip %0d",
               sb.status_seen[ST_OK], sb.status_seen[ST_BAD_TYPE],
               sb.status_seen[ST_OFFSET_PAST], sb.status_seen[ST_ARRAY_PAST],
               sb.status_seen[ST_STRING_END], sb.status_seen[ST_SKIPPED]);
      if (sb.failures == 0) begin
         $display("package_header_index_checker_top verification clean");
      end else begin
         $display("package_header_index_checker_top verification failed");
      end
      $finish;
   end

endmodule
